/* hdl/tmf_pkg.sv */
// Package: shared types, constants and the mode transition table for the target mode bank.
`default_nettype none
package tmf_pkg;

  // Bank size and derived index width
  localparam int TARGET_COUNT = 16;
  localparam int IDX_W        = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
  localparam int NUM_W        = 8;
  localparam int EV_W         = 5;
  localparam int MODE_W       = 4;
  localparam int CNT_W        = 32;
  localparam int TIME_W       = 64;

  // Operation codes
  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  // Modes
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF        = 4'd0,
    MODE_SAFE       = 4'd1,
    MODE_COUNTDOWN  = 4'd2,
    MODE_ACTIVE     = 4'd3,
    MODE_HIT        = 4'd4,
    MODE_PENALTY    = 4'd5,
    MODE_LOCKED     = 4'd6,
    MODE_CALIB      = 4'd7,
    MODE_SENSOR_ERR = 4'd8,
    MODE_MAINT      = 4'd9,
    MODE_DISABLED   = 4'd10,
    MODE_ERROR      = 4'd11
  } mode_t;

  // Event codes
  localparam logic [EV_W-1:0] EV_ENABLE           = 5'd0;
  localparam logic [EV_W-1:0] EV_DISABLE          = 5'd1;
  localparam logic [EV_W-1:0] EV_ARM              = 5'd2;
  localparam logic [EV_W-1:0] EV_DISARM           = 5'd3;
  localparam logic [EV_W-1:0] EV_COUNTDOWN        = 5'd4;
  localparam logic [EV_W-1:0] EV_HIT_VALID        = 5'd5;
  localparam logic [EV_W-1:0] EV_HIT_PENALTY      = 5'd6;
  localparam logic [EV_W-1:0] EV_HIT_CLEARED      = 5'd7;
  localparam logic [EV_W-1:0] EV_ROUND_END        = 5'd8;
  localparam logic [EV_W-1:0] EV_CALIB_START      = 5'd9;
  localparam logic [EV_W-1:0] EV_CALIB_END        = 5'd10;
  localparam logic [EV_W-1:0] EV_LOCK             = 5'd11;
  localparam logic [EV_W-1:0] EV_UNLOCK           = 5'd12;
  localparam logic [EV_W-1:0] EV_SENSOR_FAULT     = 5'd13;
  localparam logic [EV_W-1:0] EV_SENSOR_RECOVERED = 5'd14;
  localparam logic [EV_W-1:0] EV_MAINT_ON         = 5'd15;
  localparam logic [EV_W-1:0] EV_MAINT_OFF        = 5'd16;
  localparam logic [EV_W-1:0] EV_ADMIN_DISABLE    = 5'd17;
  localparam logic [EV_W-1:0] EV_ADMIN_ENABLE     = 5'd18;
  localparam logic [EV_W-1:0] EV_ERROR            = 5'd19;
  localparam logic [EV_W-1:0] EV_ERROR_CLEAR      = 5'd20;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic exec;     // look up, update the target, load the result
  } ctl_cmd_t;

  // Table lookup answer
  typedef struct packed {
    logic              hit;
    logic [MODE_W-1:0] next;
  } rule_t;

  // One result beat
  typedef struct packed {
    logic              index_ok;
    logic              allowed;
    logic [MODE_W-1:0] mode_now;
    logic [MODE_W-1:0] mode_before;
    logic              is_enabled;
    logic              is_scorable;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  move_total;
    logic [CNT_W-1:0]  refused_total;
    logic [TIME_W-1:0] entered_time_us;
  } res_t;

  // Fixed transition table: (mode, event) -> next mode, hit = pair allowed
  function automatic rule_t rule_lookup(input logic [MODE_W-1:0] mode,
                                        input logic [EV_W-1:0] ev);
    rule_t r;
    r.hit  = 1'b1;
    r.next = MODE_OFF;
    case (mode)
      MODE_OFF: begin
        case (ev) inside
          EV_ENABLE:        r.next = MODE_SAFE;
          EV_CALIB_START:   r.next = MODE_CALIB;
          EV_MAINT_ON:      r.next = MODE_MAINT;
          EV_ADMIN_DISABLE: r.next = MODE_DISABLED;
          EV_SENSOR_FAULT:  r.next = MODE_SENSOR_ERR;
          EV_ERROR:         r.next = MODE_ERROR;
          default:          r.hit  = 1'b0;
        endcase
      end
      MODE_SAFE: begin
        case (ev) inside
          EV_ARM:                  r.next = MODE_ACTIVE;
          EV_COUNTDOWN:            r.next = MODE_COUNTDOWN;
          EV_HIT_PENALTY:          r.next = MODE_PENALTY;
          EV_LOCK:                 r.next = MODE_LOCKED;
          EV_DISABLE, EV_ROUND_END: r.next = MODE_OFF;
          EV_CALIB_START:          r.next = MODE_CALIB;
          EV_MAINT_ON:             r.next = MODE_MAINT;
          EV_ADMIN_DISABLE:        r.next = MODE_DISABLED;
          EV_SENSOR_FAULT:         r.next = MODE_SENSOR_ERR;
          EV_ERROR:                r.next = MODE_ERROR;
          default:                 r.hit  = 1'b0;
        endcase
      end
      MODE_COUNTDOWN: begin
        case (ev) inside
          EV_ARM:       r.next = MODE_ACTIVE;
          EV_DISARM:    r.next = MODE_SAFE;
          EV_ROUND_END: r.next = MODE_OFF;
          EV_ERROR:     r.next = MODE_ERROR;
          default:      r.hit  = 1'b0;
        endcase
      end
      MODE_ACTIVE: begin
        case (ev) inside
          EV_HIT_VALID:    r.next = MODE_HIT;
          EV_DISARM:       r.next = MODE_SAFE;
          EV_LOCK:         r.next = MODE_LOCKED;
          EV_ROUND_END:    r.next = MODE_OFF;
          EV_SENSOR_FAULT: r.next = MODE_SENSOR_ERR;
          EV_ERROR:        r.next = MODE_ERROR;
          default:         r.hit  = 1'b0;
        endcase
      end
      MODE_HIT, MODE_PENALTY: begin
        case (ev) inside
          EV_HIT_CLEARED: r.next = MODE_SAFE;
          EV_ARM:         r.next = MODE_ACTIVE;
          EV_ROUND_END:   r.next = MODE_OFF;
          EV_ERROR:       r.next = MODE_ERROR;
          default:        r.hit  = 1'b0;
        endcase
      end
      MODE_LOCKED: begin
        case (ev) inside
          EV_UNLOCK:    r.next = MODE_SAFE;
          EV_ROUND_END: r.next = MODE_OFF;
          EV_ERROR:     r.next = MODE_ERROR;
          default:      r.hit  = 1'b0;
        endcase
      end
      MODE_CALIB: begin
        case (ev) inside
          EV_CALIB_END:    r.next = MODE_SAFE;
          EV_SENSOR_FAULT: r.next = MODE_SENSOR_ERR;
          EV_ERROR:        r.next = MODE_ERROR;
          default:         r.hit  = 1'b0;
        endcase
      end
      MODE_SENSOR_ERR: begin
        case (ev) inside
          EV_SENSOR_RECOVERED: r.next = MODE_SAFE;
          EV_ADMIN_DISABLE:    r.next = MODE_DISABLED;
          EV_MAINT_ON:         r.next = MODE_MAINT;
          default:             r.hit  = 1'b0;
        endcase
      end
      MODE_MAINT: begin
        case (ev) inside
          EV_MAINT_OFF:     r.next = MODE_SAFE;
          EV_ADMIN_DISABLE: r.next = MODE_DISABLED;
          EV_CALIB_START:   r.next = MODE_CALIB;
          default:          r.hit  = 1'b0;
        endcase
      end
      MODE_DISABLED: begin
        case (ev) inside
          EV_ADMIN_ENABLE: r.next = MODE_SAFE;
          default:         r.hit  = 1'b0;
        endcase
      end
      MODE_ERROR: begin
        case (ev) inside
          EV_ERROR_CLEAR:   r.next = MODE_SAFE;
          EV_ADMIN_DISABLE: r.next = MODE_DISABLED;
          EV_MAINT_ON:      r.next = MODE_MAINT;
          default:          r.hit  = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tmf_req_if.sv */
// Interface: request channel carrying one event beat.
`default_nettype none
interface tmf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [tmf_pkg::NUM_W-1:0]  target_number;
  logic [tmf_pkg::EV_W-1:0]   event_code;
  logic [tmf_pkg::TIME_W-1:0] time_us;

  modport source (output valid, output op, output target_number, output event_code,
                  output time_us, input ready);
  modport sink (input valid, input op, input target_number, input event_code,
                input time_us, output ready);
endinterface
`default_nettype wire

/* hdl/tmf_rsp_if.sv */
// Interface: response channel carrying one target status beat.
`default_nettype none
interface tmf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       index_ok;
  logic                       allowed;
  logic [tmf_pkg::MODE_W-1:0] mode_now;
  logic [tmf_pkg::MODE_W-1:0] mode_before;
  logic                       is_enabled;
  logic                       is_scorable;
  logic [tmf_pkg::CNT_W-1:0]  hit_total;
  logic [tmf_pkg::CNT_W-1:0]  move_total;
  logic [tmf_pkg::CNT_W-1:0]  refused_total;
  logic [tmf_pkg::TIME_W-1:0] entered_time_us;

  modport source (output valid, output index_ok, output allowed, output mode_now,
                  output mode_before, output is_enabled, output is_scorable,
                  output hit_total, output move_total, output refused_total,
                  output entered_time_us, input ready);
  modport sink (input valid, input index_ok, input allowed, input mode_now,
                input mode_before, input is_enabled, input is_scorable,
                input hit_total, input move_total, input refused_total,
                input entered_time_us, output ready);
endinterface
`default_nettype wire

/* hdl/tmf_ctrl.sv */
// Controller: sequences capture, table update and response handoff for one beat at a time.
`default_nettype none
module tmf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output tmf_pkg::ctl_cmd_t      cmd
);
  import tmf_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while response pending");
  a_exec_to_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid) else $error("update not followed by response");
  a_resp_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("response dropped while stalled");
  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.exec) else $error("captured beat not executed");

endmodule
`default_nettype wire

/* hdl/tmf_dp.sv */
// Datapath: per-target mode bank, table lookup, counters and result register.
`default_nettype none
module tmf_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tmf_pkg::ctl_cmd_t          cmd,
  input  wire logic                       op,
  input  wire logic [tmf_pkg::NUM_W-1:0]  target_number,
  input  wire logic [tmf_pkg::EV_W-1:0]   event_code,
  input  wire logic [tmf_pkg::TIME_W-1:0] time_us,
  output tmf_pkg::res_t                   res
);
  import tmf_pkg::*;

  // Captured beat
  logic              op_q;
  logic              idx_ok_q;
  logic [IDX_W-1:0]  idx_q;
  logic [EV_W-1:0]   ev_q;
  logic [TIME_W-1:0] time_q;

  // Per-target state
  logic [MODE_W-1:0] mode_store       [TARGET_COUNT];
  logic [MODE_W-1:0] prior_mode_store [TARGET_COUNT];
  logic              enable_store     [TARGET_COUNT];
  logic [CNT_W-1:0]  hit_count_store  [TARGET_COUNT];
  logic [CNT_W-1:0]  move_count_store [TARGET_COUNT];
  logic [CNT_W-1:0]  refuse_count_store [TARGET_COUNT];
  logic [TIME_W-1:0] entry_time_store [TARGET_COUNT];

  logic              idx_ok;
  logic [IDX_W-1:0]  num_m1;
  rule_t             rule;
  logic [MODE_W-1:0] cur_mode;
  logic              move;
  logic              refuse;
  logic [MODE_W-1:0] mode_n;
  logic [MODE_W-1:0] prior_n;
  logic              en_n;
  logic [CNT_W-1:0]  hit_n;
  logic [CNT_W-1:0]  moves_n;
  logic [CNT_W-1:0]  refuse_n;
  logic [TIME_W-1:0] time_n;
  res_t              res_next;

  // Range check of the 1-based target number
  assign idx_ok = (target_number != '0) && (target_number <= NUM_W'(TARGET_COUNT));
  assign num_m1 = IDX_W'(target_number - NUM_W'(1));

  // Capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op;
      idx_ok_q <= idx_ok;
      idx_q    <= num_m1;
      ev_q     <= event_code;
      time_q   <= time_us;
    end
  end

  // Lookup and next values of the selected target
  assign cur_mode = mode_store[idx_q];
  assign rule     = rule_lookup(cur_mode, ev_q);
  assign move     = (op_q == OP_APPLY) && rule.hit;
  assign refuse   = (op_q == OP_APPLY) && !rule.hit;

  always_comb begin
    mode_n   = move ? rule.next : cur_mode;
    prior_n  = move ? cur_mode : prior_mode_store[idx_q];
    moves_n  = move_count_store[idx_q] + CNT_W'(move);
    refuse_n = refuse_count_store[idx_q] + CNT_W'(refuse);
    hit_n    = hit_count_store[idx_q] + CNT_W'(move && (ev_q == EV_HIT_VALID));
    time_n   = move ? time_q : entry_time_store[idx_q];
    en_n     = enable_store[idx_q];
    if (move && (rule.next == MODE_DISABLED)) en_n = 1'b0;
    if (move && (ev_q == EV_ADMIN_ENABLE)) en_n = 1'b1;
  end

  // Result of this beat; all zero for a bad target number
  always_comb begin
    res_next = '0;
    if (idx_ok_q) begin
      res_next.index_ok        = 1'b1;
      res_next.allowed         = rule.hit;
      res_next.mode_now        = mode_n;
      res_next.mode_before     = prior_n;
      res_next.is_enabled      = en_n;
      res_next.is_scorable     = en_n && (mode_n == MODE_ACTIVE);
      res_next.hit_total       = hit_n;
      res_next.move_total      = moves_n;
      res_next.refused_total   = refuse_n;
      res_next.entered_time_us = time_n;
    end
  end

  // Target bank write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TARGET_COUNT; i++) begin
        mode_store[i]         <= MODE_OFF;
        prior_mode_store[i]   <= MODE_OFF;
        enable_store[i]       <= 1'b1;
        hit_count_store[i]    <= '0;
        move_count_store[i]   <= '0;
        refuse_count_store[i] <= '0;
        entry_time_store[i]   <= '0;
      end
    end else if (cmd.exec && idx_ok_q) begin
      mode_store[idx_q]         <= mode_n;
      prior_mode_store[idx_q]   <= prior_n;
      enable_store[idx_q]       <= en_n;
      hit_count_store[idx_q]    <= hit_n;
      move_count_store[idx_q]   <= moves_n;
      refuse_count_store[idx_q] <= refuse_n;
      entry_time_store[idx_q]   <= time_n;
    end
  end

  // Result register, held until the response beat is taken
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/target_mode_table_fsm.sv */
// A request beat is captured as it is taken in idle, the bank is updated in exec, and the
//   response is then offered from resp; the controller handles one beat at a time
//   (capture, bank update, response handoff).
// The next request is taken in the cycle after the response beat is taken.
// Reset (rst, synchronous): all targets go to off with prior mode off, enabled,
//   counters and entry times zero; no response pending.
`default_nettype none
module target_mode_table_fsm (
  input  wire logic  clk,
  input  wire logic  rst,
  tmf_req_if.sink    req,
  tmf_rsp_if.source  rsp
);
  import tmf_pkg::*;

  ctl_cmd_t cmd;
  res_t     res;

  // Sequencer
  tmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Bank and lookup
  tmf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (req.op),
    .target_number (req.target_number),
    .event_code    (req.event_code),
    .time_us       (req.time_us),
    .res           (res)
  );

  // Response payload
  assign rsp.index_ok        = res.index_ok;
  assign rsp.allowed         = res.allowed;
  assign rsp.mode_now        = res.mode_now;
  assign rsp.mode_before     = res.mode_before;
  assign rsp.is_enabled      = res.is_enabled;
  assign rsp.is_scorable     = res.is_scorable;
  assign rsp.hit_total       = res.hit_total;
  assign rsp.move_total      = res.move_total;
  assign rsp.refused_total   = res.refused_total;
  assign rsp.entered_time_us = res.entered_time_us;

endmodule
`default_nettype wire

/* dv/target_mode_table_fsm_tb.sv */
// Testbench for target_mode_table_fsm: random and directed event beats checked against a bank predictor.
`default_nettype none
module target_mode_table_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmf_pkg::*;

  localparam int RANDOM_BEATS = 1200;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  // One request beat
  typedef struct packed {
    logic              op;
    logic [NUM_W-1:0]  target_number;
    logic [EV_W-1:0]   event_code;
    logic [TIME_W-1:0] time_us;
  } beat_t;

  // Answer of the mode table for one (mode, event) pair
  typedef struct packed {
    logic  legal;
    mode_t dest;
  } move_t;

  logic clk = 1'b0;
  logic rst;

  tmf_req_if req_ch ();
  tmf_rsp_if rsp_ch ();

  target_mode_table_fsm dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bank state as predicted
  mode_t             mode_tab    [TARGET_COUNT];
  mode_t             prior_tab   [TARGET_COUNT];
  logic              enabled_tab [TARGET_COUNT];
  logic [CNT_W-1:0]  hit_tab     [TARGET_COUNT];
  logic [CNT_W-1:0]  moves_tab   [TARGET_COUNT];
  logic [CNT_W-1:0]  refuse_tab  [TARGET_COUNT];
  logic [TIME_W-1:0] entry_tab   [TARGET_COUNT];

  // Modes as the stimulus side sees them, used to build legal event chains
  mode_t plan_mode [TARGET_COUNT];

  beat_t pending_beats [$];
  res_t  status_due [$];
  beat_t held_beat;

  int beats_sent  = 0;
  int total_beats = 1;
  int phase       = 0;
  int mismatches  = 0;
  int idle_cycles = 0;

  // Idle percentages per phase: none, sender only, receiver only, both
  int send_idle_pct [4] = '{0, 51, 0, 16};
  int rcv_stall_pct [4] = '{0, 0, 51, 16};

  // Mode table: {mode, event} -> destination
  function automatic move_t transition_of(mode_t m, logic [EV_W-1:0] ev);
    move_t mv;
    mv.legal = 1'b1;
    mv.dest  = MODE_OFF;
    case ({m, ev})
      {MODE_OFF, EV_ENABLE}, {MODE_HIT, EV_HIT_CLEARED}, {MODE_PENALTY, EV_HIT_CLEARED},
      {MODE_LOCKED, EV_UNLOCK}, {MODE_CALIB, EV_CALIB_END},
      {MODE_SENSOR_ERR, EV_SENSOR_RECOVERED}, {MODE_MAINT, EV_MAINT_OFF},
      {MODE_DISABLED, EV_ADMIN_ENABLE}, {MODE_ERROR, EV_ERROR_CLEAR},
      {MODE_COUNTDOWN, EV_DISARM}, {MODE_ACTIVE, EV_DISARM}:
        mv.dest = MODE_SAFE;
      {MODE_OFF, EV_CALIB_START}, {MODE_SAFE, EV_CALIB_START}, {MODE_MAINT, EV_CALIB_START}:
        mv.dest = MODE_CALIB;
      {MODE_OFF, EV_MAINT_ON}, {MODE_SAFE, EV_MAINT_ON}, {MODE_SENSOR_ERR, EV_MAINT_ON},
      {MODE_ERROR, EV_MAINT_ON}:
        mv.dest = MODE_MAINT;
      {MODE_OFF, EV_ADMIN_DISABLE}, {MODE_SAFE, EV_ADMIN_DISABLE},
      {MODE_SENSOR_ERR, EV_ADMIN_DISABLE}, {MODE_MAINT, EV_ADMIN_DISABLE},
      {MODE_ERROR, EV_ADMIN_DISABLE}:
        mv.dest = MODE_DISABLED;
      {MODE_OFF, EV_SENSOR_FAULT}, {MODE_SAFE, EV_SENSOR_FAULT},
      {MODE_ACTIVE, EV_SENSOR_FAULT}, {MODE_CALIB, EV_SENSOR_FAULT}:
        mv.dest = MODE_SENSOR_ERR;
      {MODE_OFF, EV_ERROR}, {MODE_SAFE, EV_ERROR}, {MODE_COUNTDOWN, EV_ERROR},
      {MODE_ACTIVE, EV_ERROR}, {MODE_HIT, EV_ERROR}, {MODE_PENALTY, EV_ERROR},
      {MODE_LOCKED, EV_ERROR}, {MODE_CALIB, EV_ERROR}:
        mv.dest = MODE_ERROR;
      {MODE_SAFE, EV_ARM}, {MODE_COUNTDOWN, EV_ARM}, {MODE_HIT, EV_ARM},
      {MODE_PENALTY, EV_ARM}:
        mv.dest = MODE_ACTIVE;
      {MODE_SAFE, EV_COUNTDOWN}:
        mv.dest = MODE_COUNTDOWN;
      {MODE_SAFE, EV_HIT_PENALTY}:
        mv.dest = MODE_PENALTY;
      {MODE_SAFE, EV_LOCK}, {MODE_ACTIVE, EV_LOCK}:
        mv.dest = MODE_LOCKED;
      {MODE_ACTIVE, EV_HIT_VALID}:
        mv.dest = MODE_HIT;
      {MODE_SAFE, EV_DISABLE}, {MODE_SAFE, EV_ROUND_END}, {MODE_COUNTDOWN, EV_ROUND_END},
      {MODE_ACTIVE, EV_ROUND_END}, {MODE_HIT, EV_ROUND_END}, {MODE_PENALTY, EV_ROUND_END},
      {MODE_LOCKED, EV_ROUND_END}:
        mv.dest = MODE_OFF;
      default:
        mv.legal = 1'b0;
    endcase
    return mv;
  endfunction

  // Apply one accepted beat to the predicted bank and return the status it reports
  function automatic res_t advance_target(beat_t b);
    res_t  r;
    move_t mv;
    int    k;
    r = '0;
    if (b.target_number == 0 || b.target_number > TARGET_COUNT) begin
      return r;
    end
    k  = b.target_number - 1;
    mv = transition_of(mode_tab[k], b.event_code);
    if (b.op == OP_APPLY) begin
      if (!mv.legal) begin
        refuse_tab[k] += 1;
      end else begin
        prior_tab[k]  = mode_tab[k];
        mode_tab[k]   = mv.dest;
        moves_tab[k] += 1;
        entry_tab[k]  = b.time_us;
        if (b.event_code == EV_HIT_VALID) hit_tab[k] += 1;
        if (mv.dest == MODE_DISABLED) enabled_tab[k] = 1'b0;
        if (b.event_code == EV_ADMIN_ENABLE) enabled_tab[k] = 1'b1;
      end
    end
    r.index_ok        = 1'b1;
    r.allowed         = mv.legal;
    r.mode_now        = mode_tab[k];
    r.mode_before     = prior_tab[k];
    r.is_enabled      = enabled_tab[k];
    r.is_scorable     = enabled_tab[k] && (mode_tab[k] == MODE_ACTIVE);
    r.hit_total       = hit_tab[k];
    r.move_total      = moves_tab[k];
    r.refused_total   = refuse_tab[k];
    r.entered_time_us = entry_tab[k];
    return r;
  endfunction

  // Queue a beat and follow its effect on the stimulus-side modes
  function automatic void plan_beat(logic op, int num, logic [EV_W-1:0] ev,
                                    logic [TIME_W-1:0] t);
    beat_t b;
    move_t mv;
    b.op            = op;
    b.target_number = num[NUM_W-1:0];
    b.event_code    = ev;
    b.time_us       = t;
    pending_beats.push_back(b);
    if (op == OP_APPLY && num >= 1 && num <= TARGET_COUNT) begin
      mv = transition_of(plan_mode[num-1], ev);
      if (mv.legal) plan_mode[num-1] = mv.dest;
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: predicts each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        status_due.push_back(advance_target(held_beat));
        beats_sent++;
        phase <= (beats_sent * 4 / total_beats > 3) ? 3 : beats_sent * 4 / total_beats;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct[phase]) begin
          held_beat            = pending_beats.pop_front();
          req_ch.valid         <= 1'b1;
          req_ch.op            <= held_beat.op;
          req_ch.target_number <= held_beat.target_number;
          req_ch.event_code    <= held_beat.event_code;
          req_ch.time_us       <= held_beat.time_us;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each status beat with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_due.size() == 0) begin
          $error("status beat with no prediction outstanding");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("index_ok", 64'(want.index_ok), 64'(rsp_ch.index_ok));
          check_field("allowed", 64'(want.allowed), 64'(rsp_ch.allowed));
          check_field("mode_now", 64'(want.mode_now), 64'(rsp_ch.mode_now));
          check_field("mode_before", 64'(want.mode_before), 64'(rsp_ch.mode_before));
          check_field("is_enabled", 64'(want.is_enabled), 64'(rsp_ch.is_enabled));
          check_field("is_scorable", 64'(want.is_scorable), 64'(rsp_ch.is_scorable));
          check_field("hit_total", 64'(want.hit_total), 64'(rsp_ch.hit_total));
          check_field("move_total", 64'(want.move_total), 64'(rsp_ch.move_total));
          check_field("refused_total", 64'(want.refused_total),
                      64'(rsp_ch.refused_total));
          check_field("entered_time_us", want.entered_time_us, rsp_ch.entered_time_us);
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct[phase]);
    end
  end

  // Watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [EV_W-1:0]   legal_evs [$];
    move_t             mv;
    logic [TIME_W-1:0] ones;
    int                r;
    int                num;

    rst  = 1'b1;
    ones = '1;

    for (int i = 0; i < TARGET_COUNT; i++) begin
      mode_tab[i]    = MODE_OFF;
      prior_tab[i]   = MODE_OFF;
      enabled_tab[i] = 1'b1;
      hit_tab[i]     = '0;
      moves_tab[i]   = '0;
      refuse_tab[i]  = '0;
      entry_tab[i]   = '0;
      plan_mode[i]   = MODE_OFF;
    end

    // Directed: out-of-range targets, events above the table, probes, enable flag
    plan_beat(OP_PROBE, 0, EV_ENABLE, '0);
    plan_beat(OP_APPLY, TARGET_COUNT + 1, EV_ENABLE, 64'd5);
    plan_beat(OP_APPLY, 255, 5'd31, ones);
    plan_beat(OP_PROBE, 1, EV_ENABLE, 64'd7);
    plan_beat(OP_APPLY, 1, 5'd31, 64'd9);
    plan_beat(OP_PROBE, 1, EV_W'(EV_ERROR_CLEAR + 1), 64'd10);
    plan_beat(OP_APPLY, 1, EV_ENABLE, ones);
    plan_beat(OP_APPLY, 1, EV_ARM, 64'd100);
    plan_beat(OP_PROBE, 1, EV_HIT_VALID, 64'd101);
    plan_beat(OP_APPLY, 1, EV_HIT_VALID, 64'd102);
    plan_beat(OP_APPLY, 1, EV_HIT_CLEARED, 64'd103);
    plan_beat(OP_APPLY, 1, EV_ADMIN_DISABLE, 64'h8000_0000_0000_0000);
    plan_beat(OP_APPLY, 1, EV_ARM, 64'd104);
    plan_beat(OP_PROBE, 1, EV_ADMIN_ENABLE, 64'd105);
    plan_beat(OP_APPLY, 1, EV_ADMIN_ENABLE, 64'd106);
    plan_beat(OP_APPLY, TARGET_COUNT, EV_ERROR, 64'h5555_5555_5555_5555);
    plan_beat(OP_APPLY, TARGET_COUNT, EV_ERROR_CLEAR, 64'haaaa_aaaa_aaaa_aaaa);
    plan_beat(OP_APPLY, TARGET_COUNT, EV_LOCK, 64'd200);
    plan_beat(OP_APPLY, TARGET_COUNT, EV_UNLOCK, 64'd201);
    plan_beat(OP_APPLY, TARGET_COUNT, EV_ROUND_END, '0);
    plan_beat(OP_PROBE, TARGET_COUNT, 5'd31, ones);

    // Random: mostly legal event chains, the rest probes, refusals and bad targets
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        num = $urandom_range(TARGET_COUNT, 1);
        legal_evs.delete();
        for (int e = 0; e <= EV_ERROR_CLEAR; e++) begin
          mv = transition_of(plan_mode[num-1], e[EV_W-1:0]);
          if (mv.legal) legal_evs.push_back(e[EV_W-1:0]);
        end
        plan_beat(OP_APPLY, num, legal_evs[$urandom_range(legal_evs.size() - 1)],
                  {$urandom(), $urandom()});
      end else if (r < 80) begin
        plan_beat(OP_PROBE, $urandom_range(TARGET_COUNT, 1), EV_W'($urandom_range(31)),
                  {$urandom(), $urandom()});
      end else if (r < 90) begin
        plan_beat(OP_APPLY, $urandom_range(TARGET_COUNT, 1), EV_W'($urandom_range(31)),
                  {$urandom(), $urandom()});
      end else begin
        num = ($urandom_range(7) == 0) ? 0 : $urandom_range(255, TARGET_COUNT + 1);
        plan_beat(1'($urandom_range(1)), num, EV_W'($urandom_range(31)),
                  {$urandom(), $urandom()});
      end
    end
    total_beats = pending_beats.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || req_ch.valid || status_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
hdl/tmf_pkg.sv
hdl/tmf_req_if.sv
hdl/tmf_rsp_if.sv
hdl/tmf_ctrl.sv
hdl/tmf_dp.sv
hdl/target_mode_table_fsm.sv
dv/target_mode_table_fsm_tb.sv
